>>> hdl/bqpfb_pkg.sv
// ----------------------------------------------------------------------------
// Bounded queue package
// Field widths, operation and status codes and the shared types of the
// bounded queue with push at the front and at the back.
// ----------------------------------------------------------------------------
package bqpfb_pkg;

    // Field widths of the stream items and the configuration register.
    localparam int OP_W       = 2;
    localparam int HANDLE_W   = 64;
    localparam int BYTES_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int CAP_W      = 5;
    localparam int COUNT_W    = 5;
    localparam int TOTAL_W    = 20;
    localparam int IN_DATA_W  = HANDLE_W + BYTES_W;
    localparam int OUT_FILL_W = HANDLE_W + BYTES_W + COUNT_W + TOTAL_W;
    localparam int OUT_DATA_W = ((OUT_FILL_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FILL_W;

    // Operation codes carried in the input tuser.
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd1;
    localparam logic [OP_W-1:0] OP_POP    = 2'd2;

    // Status codes carried in the output tuser.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // One stored queue entry.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  bytes;
    } entry_t;

    // Outcome of one item, handed from the control stage to the result stage.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                add_ok;
        logic                pop_ok;
        logic [BYTES_W-1:0]  add_bytes;
    } step_ctl_t;

endpackage

>>> hdl/bounded_queue_push_front_back.sv
// The queue takes one item per clock and returns one result item for each,
// after it passes the input register, the control stage with the store read
// and the result register; the store's registered read port sets the
// middle stage. The whole pipeline moves together, so while a result waits
// with m_tready low no new item is accepted. With m_tready high an item may
// be accepted every cycle. Entries that were never written are never returned.
// ----------------------------------------------------------------------------
// Bounded queue with push at the front and at the back
// Circular store of handle and byte-size entries with append, urgent push at
// the head and pop, a configurable entry limit and a running byte total.
// ----------------------------------------------------------------------------
module bounded_queue_push_front_back #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration: capacity_limit.
    input  logic                                cfg_wr_en,
    input  logic [bqpfb_pkg::CAP_W-1:0]         cfg_wr_data,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bqpfb_pkg::IN_DATA_W-1:0]     s_tdata,   // entry_handle, entry_bytes
    input  logic [bqpfb_pkg::OP_W-1:0]          s_tuser,   // op
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bqpfb_pkg::OUT_DATA_W-1:0]    m_tdata,   // popped_handle, popped_bytes,
                                                           // entry_count, byte_total, zero fill
    output logic [bqpfb_pkg::STATUS_W-1:0]      m_tuser    // status
);

    import bqpfb_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int CNT_W  = (CW > COUNT_W) ? CW : COUNT_W;

    logic                capacity_limit_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic                advance;
    logic                in_valid_reg;
    logic [OP_W-1:0]     in_op_reg;
    logic [HANDLE_W-1:0] in_handle_reg;
    logic [BYTES_W-1:0]  in_bytes_reg;
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    entry_t              ram_wr_data;
    logic [ADDR_W-1:0]   ram_rd_addr;
    entry_t              ram_rd_data;
    logic                stage_valid;
    step_ctl_t           stage_ctl;
    logic [CNT_W-1:0]    stage_count;
    logic [STATUS_W-1:0] out_status;
    logic [HANDLE_W-1:0] out_handle;
    logic [BYTES_W-1:0]  out_bytes;
    logic [COUNT_W-1:0]  out_count;
    logic [TOTAL_W-1:0]  out_total;

    // The pipeline moves when the result register is free or being taken.
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // Capacity limit register; the flag marks that a nonzero limit has been written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg            <= '0;
            capacity_limit_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            cap_reg            <= cfg_wr_data;
            capacity_limit_reg <= (cfg_wr_data != '0);
        end
    end

    // Input register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (advance && s_tvalid)
        begin
            in_op_reg     <= s_tuser;
            in_handle_reg <= s_tdata[HANDLE_W-1:0];
            in_bytes_reg  <= s_tdata[IN_DATA_W-1:HANDLE_W];
        end
    end

    // Control stage.
    bqpfb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .in_valid       (in_valid_reg),
        .in_op          (in_op_reg),
        .in_handle      (in_handle_reg),
        .in_bytes       (in_bytes_reg),
        .capacity_limit (capacity_limit_reg ? cap_reg : '0),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data),
        .ram_rd_addr    (ram_rd_addr),
        .stage_valid    (stage_valid),
        .stage_ctl      (stage_ctl),
        .stage_count    (stage_count)
    );

    // Entry store.
    bqpfb_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (advance),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Result stage.
    bqpfb_acc #(
        .DEPTH (DEPTH)
    ) u_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_ctl   (stage_ctl),
        .stage_count (stage_count),
        .rd_data     (ram_rd_data),
        .out_valid   (m_tvalid),
        .out_status  (out_status),
        .out_handle  (out_handle),
        .out_bytes   (out_bytes),
        .out_count   (out_count),
        .out_total   (out_total)
    );

    // Pack the result item.
    assign m_tuser = out_status;
    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_total, out_count, out_bytes, out_handle};

endmodule

>>> hdl/bqpfb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bqpfb_ram #(
    parameter int   WIDTH  = 80,
    parameter int   DEPTH  = 16,
    localparam int  ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/bqpfb_ctrl.sv
// ----------------------------------------------------------------------------
// Queue control stage
// Holds the head pointer and entry count, decides each item's outcome and
// drives the store's write port and head read address.
// ----------------------------------------------------------------------------
module bqpfb_ctrl #(
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int CW     = $clog2(DEPTH + 1),
    localparam int CNT_W  = (CW > bqpfb_pkg::COUNT_W) ? CW : bqpfb_pkg::COUNT_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  logic [bqpfb_pkg::OP_W-1:0]        in_op,
    input  logic [bqpfb_pkg::HANDLE_W-1:0]    in_handle,
    input  logic [bqpfb_pkg::BYTES_W-1:0]     in_bytes,
    input  logic [bqpfb_pkg::CAP_W-1:0]       capacity_limit,
    output logic                              ram_wr_en,
    output logic [ADDR_W-1:0]                 ram_wr_addr,
    output bqpfb_pkg::entry_t                 ram_wr_data,
    output logic [ADDR_W-1:0]                 ram_rd_addr,
    output logic                              stage_valid,
    output bqpfb_pkg::step_ctl_t              stage_ctl,
    output logic [CNT_W-1:0]                  stage_count
);

    import bqpfb_pkg::*;

    localparam logic [ADDR_W:0]   DEPTH_SUM = (ADDR_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);

    logic [ADDR_W-1:0] head_reg;
    logic [ADDR_W-1:0] head_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              stage_valid_reg;
    step_ctl_t         stage_ctl_reg;
    step_ctl_t         ctl_next;
    logic [CNT_W-1:0]  cap_ext;
    logic              is_full;
    logic [ADDR_W:0]   tail_sum;
    logic [ADDR_W-1:0] tail_slot;
    logic [ADDR_W-1:0] front_slot;
    logic [ADDR_W-1:0] after_head;
    logic [ADDR_W-1:0] wr_slot;

    // Slot arithmetic around the circular store.
    always_comb
    begin
        cap_ext    = CNT_W'(capacity_limit);
        is_full    = (count_reg >= DEPTH_CNT) ||
                     ((capacity_limit != '0) && (count_reg >= cap_ext));
        tail_sum   = {1'b0, head_reg} + (ADDR_W + 1)'(count_reg);
        tail_slot  = (tail_sum >= DEPTH_SUM) ? ADDR_W'(tail_sum - DEPTH_SUM)
                                             : tail_sum[ADDR_W-1:0];
        front_slot = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;
        after_head = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    end

    // Decide the outcome of the item in the input register.
    always_comb
    begin
        ctl_next.status    = ST_DONE;
        ctl_next.add_ok    = 1'b0;
        ctl_next.pop_ok    = 1'b0;
        ctl_next.add_bytes = in_bytes;
        head_next          = head_reg;
        count_next         = count_reg;
        wr_slot            = tail_slot;
        unique case (in_op)
            OP_APPEND:
            begin
                if (is_full)
                begin
                    ctl_next.status = ST_FULL;
                end
                else
                begin
                    ctl_next.add_ok = 1'b1;
                    count_next      = count_reg + 1'b1;
                end
            end
            OP_PUSH:
            begin
                wr_slot = front_slot;
                if (is_full)
                begin
                    ctl_next.status = ST_FULL;
                end
                else
                begin
                    ctl_next.add_ok = 1'b1;
                    head_next       = front_slot;
                    count_next      = count_reg + 1'b1;
                end
            end
            OP_POP:
            begin
                if (count_reg == '0)
                begin
                    ctl_next.status = ST_EMPTY;
                end
                else
                begin
                    ctl_next.pop_ok = 1'b1;
                    head_next       = after_head;
                    count_next      = count_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Store access: write the added entry, read at the current head.
    assign ram_wr_en          = advance && in_valid && ctl_next.add_ok;
    assign ram_wr_addr        = wr_slot;
    assign ram_wr_data.handle = in_handle;
    assign ram_wr_data.bytes  = in_bytes;
    assign ram_rd_addr        = head_reg;

    // Queue pointers and stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            count_reg       <= '0;
            stage_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            stage_valid_reg <= in_valid;
            if (in_valid)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
        end
    end

    // Outcome travels with the read data into the result stage.
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            stage_ctl_reg <= ctl_next;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage_ctl   = stage_ctl_reg;
    assign stage_count = count_reg;

    // The count never goes past the store depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_CNT)
        else $error("entry count exceeds store depth");

    // An item never both adds and pops.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl_next.add_ok && ctl_next.pop_ok))
        else $error("item both adds and pops");

    // An accepted add raises the count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid && ctl_next.add_ok) |=>
        (count_reg == $past(count_reg) + 1'b1))
        else $error("add did not raise the entry count");

endmodule

>>> hdl/bqpfb_acc.sv
// ----------------------------------------------------------------------------
// Queue result stage
// Keeps the running byte total and registers the result item.
// ----------------------------------------------------------------------------
module bqpfb_acc #(
    parameter int  DEPTH = 16,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int CNT_W = (CW > bqpfb_pkg::COUNT_W) ? CW : bqpfb_pkg::COUNT_W,
    localparam int SUM_W = bqpfb_pkg::BYTES_W + CW,
    localparam int TOT_W = (SUM_W > bqpfb_pkg::TOTAL_W) ? SUM_W : bqpfb_pkg::TOTAL_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              stage_valid,
    input  bqpfb_pkg::step_ctl_t              stage_ctl,
    input  logic [CNT_W-1:0]                  stage_count,
    input  bqpfb_pkg::entry_t                 rd_data,
    output logic                              out_valid,
    output logic [bqpfb_pkg::STATUS_W-1:0]    out_status,
    output logic [bqpfb_pkg::HANDLE_W-1:0]    out_handle,
    output logic [bqpfb_pkg::BYTES_W-1:0]     out_bytes,
    output logic [bqpfb_pkg::COUNT_W-1:0]     out_count,
    output logic [bqpfb_pkg::TOTAL_W-1:0]     out_total
);

    import bqpfb_pkg::*;

    logic [TOT_W-1:0]    bytes_held_reg;
    logic [TOT_W-1:0]    bytes_held_next;
    logic [BYTES_W-1:0]  add_val;
    logic [BYTES_W-1:0]  pop_bytes;
    logic [HANDLE_W-1:0] pop_handle;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [BYTES_W-1:0]  out_bytes_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [TOTAL_W-1:0]  out_total_reg;

    // Popped entry is zero unless the pop succeeded; update the byte total.
    always_comb
    begin
        add_val         = stage_ctl.add_ok ? stage_ctl.add_bytes : '0;
        pop_bytes       = stage_ctl.pop_ok ? rd_data.bytes : '0;
        pop_handle      = stage_ctl.pop_ok ? rd_data.handle : '0;
        bytes_held_next = bytes_held_reg + TOT_W'(add_val) - TOT_W'(pop_bytes);
    end

    // Byte total and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_held_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid;
            if (stage_valid)
            begin
                bytes_held_reg <= bytes_held_next;
            end
        end
    end

    // Result item payload.
    always_ff @(posedge clk)
    begin
        if (advance && stage_valid)
        begin
            out_status_reg <= stage_ctl.status;
            out_handle_reg <= pop_handle;
            out_bytes_reg  <= pop_bytes;
            out_count_reg  <= stage_count[COUNT_W-1:0];
            out_total_reg  <= bytes_held_next[TOTAL_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_handle = out_handle_reg;
    assign out_bytes  = out_bytes_reg;
    assign out_count  = out_count_reg;
    assign out_total  = out_total_reg;

    // A failed operation returns no entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_DONE)) |->
        ((out_handle_reg == '0) && (out_bytes_reg == '0)))
        else $error("failed operation returned an entry");

    // An empty pop reports an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_EMPTY)) |->
        ((out_count_reg == '0) && (out_total_reg == '0)))
        else $error("empty pop reported held entries");

endmodule
